[src/orbbo_pkg.sv]
`default_nettype none

package orbbo_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned OCC_W       = 6;
  localparam int unsigned SLOTS_CFG_W = 7;

  localparam logic [SLOTS_CFG_W-1:0] SLOTS_RESET = 7'd64;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_READ   = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_BLOCK = 1'b1
  } state_e;

endpackage

`default_nettype wire

[src/overwriting_ring_buffer_block_ops_top.sv]
// ring buffer with overwrite of the oldest entry, block read and block delete
// push, pop and delete: the result is registered in the cycle after the transfer
// read block of n: first result goes through the memory read register and then
// the output register, then one per cycle while the output is not stalled
// reset clears pointers and occupancy and sets the slot count register to 64; the
// entry memory is not cleared, only entries written by a push are ever read
`default_nettype none

module overwriting_ring_buffer_block_ops_top
  import orbbo_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = 64,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,

  // configuration write channel
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [SLOTS_CFG_W-1:0] cfg_data_i,

  // command channel
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [1:0]             command_i,
  input  wire logic [DATA_W-1:0]      data_word_i,
  input  wire logic [COUNT_W-1:0]     block_count_i,

  // result channel
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [DATA_W-1:0]           read_value_o,
  output logic                        value_valid_o,
  output logic                        last_result_o,
  output logic [OCC_W-1:0]            occupancy_o
);

  // pointer width, and a width that holds the slot count itself
  localparam int unsigned PW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned SW   = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CW   = (SW > SLOTS_CFG_W) ? SW : SLOTS_CFG_W;
  localparam int unsigned CNTW = (SW > COUNT_W) ? SW : COUNT_W;

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  state_e                 state_q, state_d;
  logic [SLOTS_CFG_W-1:0] slots_cfg_q;
  logic [PW-1:0]          wp_q, wp_d;      // head, next slot to write
  logic [PW-1:0]          rp_q, rp_d;      // tail, oldest entry
  logic [SW-1:0]          occ_q, occ_d;    // entries held
  logic [PW-1:0]          blk_ptr_q, blk_ptr_d;  // address of the word in flight
  logic [SW-1:0]          rem_q, rem_d;    // words still to emit in a block read
  logic                   dv_q, dv_d;      // memory read data is valid

  logic                   out_valid_q, out_valid_d;
  logic [DATA_W-1:0]      out_value_q, out_value_d;
  logic                   out_vv_q, out_vv_d;
  logic                   out_last_q, out_last_d;
  logic [OCC_W-1:0]       out_occ_q, out_occ_d;

  // ---------------------------------------------------------------------------
  // entry memory: one write port, one registered read port
  // ---------------------------------------------------------------------------
  logic [WORD_BITS-1:0]   mem [MAX_SLOTS];
  logic                   wr_en;
  logic [WORD_BITS-1:0]   wr_data;
  logic                   rd_en;
  logic [PW-1:0]          rd_addr;
  logic [WORD_BITS-1:0]   rd_data_q;
  logic [DATA_W-1:0]      rd_value;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wp_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // word width adaption between the 32 bit ports and the stored word
  if (WORD_BITS >= DATA_W) begin : g_wide_word
    assign wr_data  = WORD_BITS'(data_word_i);
    assign rd_value = rd_data_q[DATA_W-1:0];
  end else begin : g_narrow_word
    assign wr_data  = data_word_i[WORD_BITS-1:0];
    assign rd_value = DATA_W'(rd_data_q);
  end

  // ---------------------------------------------------------------------------
  // slot count in use: register clamped to [2, MAX_SLOTS]
  // ---------------------------------------------------------------------------
  logic [CW-1:0] cfg_ext;
  logic [SW-1:0] slots;
  logic [SW-1:0] slots_m1;

  always_comb begin
    cfg_ext = CW'(slots_cfg_q);
    priority if (cfg_ext < CW'(2)) begin
      slots = SW'(2);
    end else if (cfg_ext > CW'(MAX_SLOTS)) begin
      slots = SW'(MAX_SLOTS);
    end else begin
      slots = SW'(cfg_ext);
    end
    slots_m1 = slots - SW'(1);
  end

  // pointer increment with wrap at the slot count
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p,
                                            input logic [SW-1:0] last_slot);
    logic [PW-1:0] r;
    if (SW'(p) == last_slot) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------
  logic  out_free;    // output register can take a result this cycle
  logic  in_xfer;
  logic  cfg_xfer;
  logic  consume;     // block read word moves into the output register
  cmd_e  cmd;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign cfg_xfer = cfg_valid_i && cfg_ready_o;
  assign cmd      = cmd_e'(command_i);

  // block length clamped to occupancy, delete clamp
  logic [CNTW-1:0] cnt_ext;
  logic [CNTW-1:0] occ_ext;
  logic [SW-1:0]   blk_n;
  logic            del_all;
  logic [SW:0]     del_sum;

  always_comb begin
    cnt_ext = CNTW'(block_count_i);
    occ_ext = CNTW'(occ_q);
    del_all = cnt_ext >= occ_ext;
    blk_n   = del_all ? occ_q : SW'(block_count_i);
    // only used when the count is below occupancy, so one wrap is enough
    del_sum = (SW + 1)'(rp_q) + (SW + 1)'(blk_n);
  end

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && (cmd == CMD_READ) && (blk_n != '0)) begin
          state_d = ST_BLOCK;
        end
      end
      ST_BLOCK: begin
        if (consume && (rem_q == SW'(1))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // outputs and datapath
  // ---------------------------------------------------------------------------
  always_comb begin
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    consume     = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = rp_q;

    wp_d        = wp_q;
    rp_d        = rp_q;
    occ_d       = occ_q;
    blk_ptr_d   = blk_ptr_q;
    rem_d       = rem_q;

    out_valid_d = out_valid_q && out_stall_i;
    out_value_d = out_value_q;
    out_vv_d    = out_vv_q;
    out_last_d  = out_last_q;
    out_occ_d   = out_occ_q;

    unique case (state_q)
      ST_IDLE: begin
        // a pending slot count write goes first, commands wait behind it
        in_stall_o  = !out_free || cfg_valid_i;
        cfg_ready_o = 1'b1;
        if (in_xfer) begin
          // default result: no data, last of this command
          out_valid_d = 1'b1;
          out_value_d = '0;
          out_vv_d    = 1'b0;
          out_last_d  = 1'b1;
          unique case (cmd)
            CMD_PUSH: begin
              wr_en = 1'b1;
              wp_d  = ptr_inc(wp_q, slots_m1);
              if (occ_q == slots_m1) begin
                // full: the oldest entry is overwritten
                rp_d = ptr_inc(rp_q, slots_m1);
              end else begin
                occ_d = occ_q + SW'(1);
              end
            end
            CMD_POP: begin
              if (occ_q != '0) begin
                rp_d  = ptr_inc(rp_q, slots_m1);
                occ_d = occ_q - SW'(1);
              end
            end
            CMD_READ: begin
              if (blk_n != '0) begin
                // first word is fetched now, results follow from ST_BLOCK
                out_valid_d = 1'b0;
                rd_en       = 1'b1;
                rd_addr     = rp_q;
                blk_ptr_d   = rp_q;
                rem_d       = blk_n;
              end
            end
            CMD_DELETE: begin
              if (del_all) begin
                rp_d  = wp_q;
                occ_d = '0;
              end else begin
                if (del_sum >= (SW + 1)'(slots)) begin
                  rp_d = PW'(del_sum - (SW + 1)'(slots));
                end else begin
                  rp_d = PW'(del_sum);
                end
                occ_d = occ_q - blk_n;
              end
            end
            default: ;
          endcase
          out_occ_d = OCC_W'(occ_d);
        end
      end
      ST_BLOCK: begin
        consume = dv_q && out_free;
        if (consume) begin
          out_valid_d = 1'b1;
          out_value_d = rd_value;
          out_vv_d    = 1'b1;
          out_last_d  = (rem_q == SW'(1));
          out_occ_d   = OCC_W'(occ_q);
          rem_d       = rem_q - SW'(1);
          if (rem_q != SW'(1)) begin
            // fetch the next word behind the one just handed over
            rd_en     = 1'b1;
            rd_addr   = ptr_inc(blk_ptr_q, slots_m1);
            blk_ptr_d = ptr_inc(blk_ptr_q, slots_m1);
          end
        end
      end
      default: ;
    endcase

    // a slot count write empties the buffer; stored words stay
    if (cfg_xfer) begin
      wp_d  = '0;
      rp_d  = '0;
      occ_d = '0;
    end

    dv_d = rd_en ? 1'b1 : (consume ? 1'b0 : dv_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slots_cfg_q <= SLOTS_RESET;
      wp_q        <= '0;
      rp_q        <= '0;
      occ_q       <= '0;
      rem_q       <= '0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      occ_q       <= occ_d;
      rem_q       <= rem_d;
      dv_q        <= dv_d;
      out_valid_q <= out_valid_d;
      if (cfg_xfer) begin
        slots_cfg_q <= cfg_data_i;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    blk_ptr_q   <= blk_ptr_d;
    out_value_q <= out_value_d;
    out_vv_q    <= out_vv_d;
    out_last_q  <= out_last_d;
    out_occ_q   <= out_occ_d;
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = out_value_q;
  assign value_valid_o = out_vv_q;
  assign last_result_o = out_last_q;
  assign occupancy_o   = out_occ_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  logic [SW-1:0] held_chk;
  assign held_chk = (wp_q >= rp_q) ? SW'(wp_q - rp_q)
                                   : SW'(slots - SW'(rp_q) + SW'(wp_q));

  a_occ_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= slots_m1)
    else $error("occupancy above capacity");

  a_occ_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == held_chk)
    else $error("occupancy count disagrees with pointers");

  a_block_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BLOCK) |-> (rem_q != '0))
    else $error("block read with nothing left to emit");

  a_dv_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q |-> (state_q == ST_BLOCK))
    else $error("read data pending outside a block read");

endmodule

`default_nettype wire
